### hw/rtl/csvf_pkg.sv
// csvf_pkg: shared types, byte codes, frame state, status and error codes
// for the csv record framer; no dependencies
`default_nettype none

package csvf_pkg;

   // record size counter width and config reset value
   localparam int unsigned LENGTH_BITS_DEF = 16;
   localparam logic [15:0] MAX_RECORD_RESET = 16'd4096;

   // special bytes
   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;

   // frame state codes
   localparam logic [1:0] FS_START    = 2'd0;
   localparam logic [1:0] FS_UNQUOTED = 2'd1;
   localparam logic [1:0] FS_QUOTED   = 2'd2;
   localparam logic [1:0] FS_CLOSED   = 2'd3;

   // result status codes
   localparam logic [1:0] ST_INSIDE = 2'd0;
   localparam logic [1:0] ST_RECORD = 2'd1;
   localparam logic [1:0] ST_END    = 2'd2;
   localparam logic [1:0] ST_ERROR  = 2'd3;

   // error codes
   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_TRUNCATED = 2'd1;
   localparam logic [1:0] ERR_TOO_LARGE = 2'd2;
   localparam logic [1:0] ERR_INVALID   = 2'd3;

   // one input word
   typedef struct packed {
      logic       end_of_input;
      logic [7:0] byte_value;
   } item_type;

   // one result word
   typedef struct packed {
      logic [31:0] record_number;
      logic [15:0] record_length;
      logic [1:0]  error_code;
      logic [1:0]  status;
      logic [7:0]  byte_out;
   } result_type;

endpackage

`default_nettype wire

### hw/rtl/csv_record_framer.sv
// csv_record_framer: top level, frames csv records from a byte stream
// depends on csvf_pkg, csvf_in_reg, csvf_core, csvf_out_reg
//
//   channel  dir  handshake          payload
//   req      in   req_tvalid/tready  tdata: byte_value; tuser: end_of_input
//   rsp      out  rsp_tvalid/tready  tdata: byte_out, record_length, record_number
//                                    tuser: status, error_code
//   csr      in   csr_we             csr_wdata: max_record_bytes
//
// one word in, one word out; a word passes the input then the result register
// one word per clock while rsp_tready is high, set by the single csvf_core step
// req_tready stays high while the result register is free or being drained
// synchronous reset clears framing state and loads the limit with 4096
// csr writes are meant for idle periods; the new limit applies to the next byte
`default_nettype none

module csv_record_framer #(
   parameter int unsigned LENGTH_BITS = csvf_pkg::LENGTH_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] byte_value
   input  wire logic        req_tuser,   // [0] end_of_input
   // result stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,   // [7:0] byte_out, [23:8] record_length,
                                         // [55:24] record_number
   output logic [3:0]       rsp_tuser,   // [1:0] status, [3:2] error_code
   // limit register
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata    // max_record_bytes
);

   csvf_pkg::item_type   req_item;
   csvf_pkg::item_type   stage_item;
   csvf_pkg::result_type step_result;
   csvf_pkg::result_type rsp_result;
   logic                 stage_valid;
   logic                 out_ready;
   logic                 step_en;

   assign req_item.byte_value   = req_tdata;
   assign req_item.end_of_input = req_tuser;

   // a held word steps when the result register can take it
   assign step_en = stage_valid && out_ready;

   csvf_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .advance   (step_en),
      .out_valid (stage_valid),
      .out_item  (stage_item)
   );

   csvf_core #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .step_en   (step_en),
      .item      (stage_item),
      .result    (step_result)
   );

   csvf_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (stage_valid),
      .in_ready   (out_ready),
      .in_result  (step_result),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (rsp_result)
   );

   // pack the result word, byte_out lowest and record_number highest
   assign rsp_tdata = {rsp_result.record_number, rsp_result.record_length,
                       rsp_result.byte_out};
   assign rsp_tuser = {rsp_result.error_code, rsp_result.status};

endmodule

`default_nettype wire

### hw/rtl/csvf_in_reg.sv
// csvf_in_reg: input register stage holding one accepted word
// depends on csvf_pkg (item_type)
`default_nettype none

module csvf_in_reg (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire csvf_pkg::item_type in_item,
   input  wire logic               advance,
   output logic                    out_valid,
   output csvf_pkg::item_type      out_item
);

   logic               valid_ff;
   logic               valid_in;
   csvf_pkg::item_type item_ff;

   // take a new word when empty or when the held one moves on
   assign in_ready  = !valid_ff || advance;
   assign valid_in  = in_valid || (valid_ff && !advance);
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_ready ? in_valid : valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/csvf_core.sv
// csvf_core: framing state registers, limit register and the per-byte step logic
// depends on csvf_pkg (codes, item_type, result_type)
`default_nettype none

module csvf_core #(
   parameter int unsigned LENGTH_BITS = csvf_pkg::LENGTH_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic [15:0]        csr_wdata,
   input  wire logic               step_en,
   input  wire csvf_pkg::item_type item,
   output csvf_pkg::result_type    result
);

   localparam int unsigned CMP_BITS = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

   logic [15:0]            max_ff;
   logic [1:0]             frame_ff, frame_in;
   logic [LENGTH_BITS-1:0] size_ff, size_in;
   logic [31:0]            done_ff, done_in;
   logic [1:0]             err_ff, err_in;
   logic                   ended_ff, ended_in;

   logic [LENGTH_BITS-1:0] size_inc;
   logic [31:0]            number;
   logic                   over_limit;
   logic                   bad;
   logic                   ends;
   logic [1:0]             frame_next;

   assign size_inc   = size_ff + LENGTH_BITS'(1);
   assign number     = (&done_ff) ? done_ff : done_ff + 32'd1;
   assign over_limit = (CMP_BITS'(size_ff) >= CMP_BITS'(max_ff)) || (&size_ff);

   // byte decode for the current frame state
   always_comb begin
      bad        = 1'b0;
      ends       = 1'b0;
      frame_next = frame_ff;
      unique case (frame_ff)
         csvf_pkg::FS_START: begin
            if (item.byte_value == csvf_pkg::CH_QUOTE) frame_next = csvf_pkg::FS_QUOTED;
            else if (item.byte_value == csvf_pkg::CH_COMMA) frame_next = csvf_pkg::FS_START;
            else if (item.byte_value == csvf_pkg::CH_NEWLINE) ends = 1'b1;
            else frame_next = csvf_pkg::FS_UNQUOTED;
         end
         csvf_pkg::FS_UNQUOTED: begin
            if (item.byte_value == csvf_pkg::CH_QUOTE) bad = 1'b1;
            else if (item.byte_value == csvf_pkg::CH_COMMA) frame_next = csvf_pkg::FS_START;
            else if (item.byte_value == csvf_pkg::CH_NEWLINE) ends = 1'b1;
         end
         csvf_pkg::FS_QUOTED: begin
            if (item.byte_value == csvf_pkg::CH_QUOTE) frame_next = csvf_pkg::FS_CLOSED;
         end
         default: begin
            if (item.byte_value == csvf_pkg::CH_QUOTE) frame_next = csvf_pkg::FS_QUOTED;
            else if (item.byte_value == csvf_pkg::CH_COMMA) frame_next = csvf_pkg::FS_START;
            else if (item.byte_value == csvf_pkg::CH_NEWLINE) ends = 1'b1;
            else bad = 1'b1;
         end
      endcase
   end

   // result and next state
   always_comb begin
      frame_in = frame_ff;
      size_in  = size_ff;
      done_in  = done_ff;
      err_in   = err_ff;
      ended_in = ended_ff;

      result.byte_out      = 8'd0;
      result.status        = csvf_pkg::ST_ERROR;
      result.error_code    = err_ff;
      result.record_length = 16'(size_ff);
      result.record_number = number;

      priority if (err_ff != csvf_pkg::ERR_NONE) begin
         // sticky error: repeat stored code
      end else if (ended_ff) begin
         result.status        = csvf_pkg::ST_END;
         result.record_length = 16'd0;
      end else if (item.end_of_input) begin
         if (size_ff == '0) begin
            ended_in             = 1'b1;
            result.status        = csvf_pkg::ST_END;
            result.record_length = 16'd0;
         end else begin
            err_in            = csvf_pkg::ERR_TRUNCATED;
            result.error_code = csvf_pkg::ERR_TRUNCATED;
         end
      end else if (over_limit) begin
         err_in            = csvf_pkg::ERR_TOO_LARGE;
         result.error_code = csvf_pkg::ERR_TOO_LARGE;
      end else begin
         size_in              = size_inc;
         result.record_length = 16'(size_inc);
         priority if (bad) begin
            err_in            = csvf_pkg::ERR_INVALID;
            result.error_code = csvf_pkg::ERR_INVALID;
         end else if (ends) begin
            result.byte_out   = item.byte_value;
            result.status     = csvf_pkg::ST_RECORD;
            result.error_code = csvf_pkg::ERR_NONE;
            done_in           = number;
            size_in           = '0;
            frame_in          = csvf_pkg::FS_START;
         end else begin
            result.byte_out   = item.byte_value;
            result.status     = csvf_pkg::ST_INSIDE;
            result.error_code = csvf_pkg::ERR_NONE;
            frame_in          = frame_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= csvf_pkg::MAX_RECORD_RESET;
      end else if (csr_we) begin
         max_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= csvf_pkg::FS_START;
         size_ff  <= '0;
         done_ff  <= 32'd0;
         err_ff   <= csvf_pkg::ERR_NONE;
         ended_ff <= 1'b0;
      end else if (step_en) begin
         frame_ff <= frame_in;
         size_ff  <= size_in;
         done_ff  <= done_in;
         err_ff   <= err_in;
         ended_ff <= ended_in;
      end
   end

`ifndef SYNTHESIS
   // once latched, an error code never changes until reset
   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      (err_ff != csvf_pkg::ERR_NONE) |=> (err_ff == $past(err_ff)))
      else $error("sticky error changed");

   // clean end and error never coexist
   a_end_err_excl: assert property (@(posedge clock) disable iff (reset)
      !(ended_ff && (err_ff != csvf_pkg::ERR_NONE)))
      else $error("clean end and error both set");

   // an error word leaves the error latched
   a_err_latched: assert property (@(posedge clock) disable iff (reset)
      (step_en && (result.status == csvf_pkg::ST_ERROR))
      |=> (err_ff != csvf_pkg::ERR_NONE))
      else $error("error word without latched error");

   // a record end restarts the size count
   a_record_restart: assert property (@(posedge clock) disable iff (reset)
      (step_en && (result.status == csvf_pkg::ST_RECORD))
      |=> ((size_ff == '0) && (frame_ff == csvf_pkg::FS_START)))
      else $error("record end did not restart framing");
`endif

endmodule

`default_nettype wire

### hw/rtl/csvf_out_reg.sv
// csvf_out_reg: result register in front of the rsp channel
// depends on csvf_pkg (result_type)
`default_nettype none

module csvf_out_reg (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire csvf_pkg::result_type in_result,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output csvf_pkg::result_type      out_result
);

   logic                 valid_ff;
   csvf_pkg::result_type result_ff;

   assign in_ready   = !valid_ff || out_ready;
   assign out_valid  = valid_ff;
   assign out_result = result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         result_ff <= in_result;
      end
   end

endmodule

`default_nettype wire

### test/csvf_tb_pkg.sv
// csvf_tb_pkg: result scoreboard for the csv record framer testbench
// predicts one result word per accepted input word; depends on csvf_pkg
package csvf_tb_pkg;
   import csvf_pkg::*;

   class framer_scoreboard;
      logic [15:0] max_bytes;
      logic [1:0]  frame_state;
      logic [15:0] record_size;
      logic [31:0] records_done;
      logic [1:0]  sticky_error;
      bit          input_ended;
      result_type  expected_words[$];
      int unsigned failures;
      int unsigned words_in;
      int unsigned words_out;
      int unsigned records_framed;

      function new();
         max_bytes      = MAX_RECORD_RESET;
         frame_state    = FS_START;
         record_size    = '0;
         records_done   = '0;
         sticky_error   = ERR_NONE;
         input_ended    = 1'b0;
         failures       = 0;
         words_in       = 0;
         words_out      = 0;
         records_framed = 0;
      endfunction

      function void set_limit(logic [15:0] value);
         max_bytes = value;
      endfunction

      // frame one accepted word and queue the result it must produce
      function void note_word(item_type word);
         result_type r;
         bit ends;
         bit bad;
         r    = '0;
         ends = 1'b0;
         bad  = 1'b0;
         words_in++;
         r.record_number = (records_done == '1) ? records_done : records_done + 32'd1;
         if (sticky_error != ERR_NONE) begin
            r.status        = ST_ERROR;
            r.error_code    = sticky_error;
            r.record_length = record_size;
         end else if (input_ended) begin
            r.status = ST_END;
         end else if (word.end_of_input) begin
            if (record_size == '0) begin
               input_ended = 1'b1;
               r.status    = ST_END;
            end else begin
               sticky_error    = ERR_TRUNCATED;
               r.status        = ST_ERROR;
               r.error_code    = ERR_TRUNCATED;
               r.record_length = record_size;
            end
         end else if (record_size >= max_bytes || record_size == '1) begin
            sticky_error    = ERR_TOO_LARGE;
            r.status        = ST_ERROR;
            r.error_code    = ERR_TOO_LARGE;
            r.record_length = record_size;
         end else begin
            record_size++;
            case (frame_state)
               FS_START: begin
                  if (word.byte_value == CH_QUOTE) frame_state = FS_QUOTED;
                  else if (word.byte_value == CH_COMMA) frame_state = FS_START;
                  else if (word.byte_value == CH_NEWLINE) ends = 1'b1;
                  else frame_state = FS_UNQUOTED;
               end
               FS_UNQUOTED: begin
                  if (word.byte_value == CH_QUOTE) bad = 1'b1;
                  else if (word.byte_value == CH_COMMA) frame_state = FS_START;
                  else if (word.byte_value == CH_NEWLINE) ends = 1'b1;
               end
               FS_QUOTED: begin
                  if (word.byte_value == CH_QUOTE) frame_state = FS_CLOSED;
               end
               default: begin
                  if (word.byte_value == CH_QUOTE) frame_state = FS_QUOTED;
                  else if (word.byte_value == CH_COMMA) frame_state = FS_START;
                  else if (word.byte_value == CH_NEWLINE) ends = 1'b1;
                  else bad = 1'b1;
               end
            endcase
            r.record_length = record_size;
            if (bad) begin
               sticky_error = ERR_INVALID;
               r.status     = ST_ERROR;
               r.error_code = ERR_INVALID;
            end else begin
               r.byte_out = word.byte_value;
               r.status   = ends ? ST_RECORD : ST_INSIDE;
               if (ends) begin
                  if (records_done != '1) records_done++;
                  record_size = '0;
                  frame_state = FS_START;
                  records_framed++;
               end
            end
         end
         expected_words.push_back(r);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            failures++;
            $error("%s: expected %0h, got %0h", name, want, got);
         end
      endfunction

      // compare one accepted result word with the oldest prediction
      function void check_word(result_type got);
         result_type want;
         words_out++;
         if (expected_words.size() == 0) begin
            failures++;
            $error("result word with nothing expected, status %0d", got.status);
            return;
         end
         want = expected_words.pop_front();
         compare_field("byte_out", 32'(want.byte_out), 32'(got.byte_out));
         compare_field("status", 32'(want.status), 32'(got.status));
         compare_field("error_code", 32'(want.error_code), 32'(got.error_code));
         compare_field("record_length", 32'(want.record_length), 32'(got.record_length));
         compare_field("record_number", want.record_number, got.record_number);
      endfunction
   endclass

endpackage

### test/tb_csv_record_framer.sv
// tb_csv_record_framer: self-checking testbench for the csv record framer
// random well-formed csv with idling on both sides, one closing case;
// depends on csvf_pkg, csvf_tb_pkg and the csv_record_framer rtl
module tb_csv_record_framer;
   timeunit 1ns;
   timeprecision 1ps;

   import csvf_pkg::*;
   import csvf_tb_pkg::*;

   // how the run ends, since errors and end of input lock the block until reset
   typedef enum int {
      CLOSE_CLEAN,
      CLOSE_TRUNCATED,
      CLOSE_TOO_LARGE,
      CLOSE_BAD_QUOTE,
      CLOSE_STRAY_BYTE,
      CLOSE_NOISE
   } closing_kind_type;

   localparam int unsigned GAP_MAX        = 16;
   localparam int unsigned HOLD_CYCLES    = 250;
   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned LONG_RECORD    = 100;
   localparam int unsigned TAIL_WORDS     = 20;
   localparam logic [7:0]  CH_RETURN      = 8'h0D;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [7:0] byte_value
   logic        req_tuser  = 1'b0; // [0] end_of_input
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;         // [7:0] byte_out, [23:8] record_length, [55:24] record_number
   logic [3:0]  rsp_tuser;         // [1:0] status, [3:2] error_code
   logic        csr_we     = 1'b0;
   logic [15:0] csr_wdata  = '0;

   framer_scoreboard sb;

   // idling knobs set by the stimulus; recv_quiet and hold_rsp are read by the result sink
   bit send_quiet = 1'b0;
   bit recv_quiet = 1'b0;
   bit hold_rsp   = 1'b0;

   int unsigned idle_cycles = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   csv_record_framer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // field content byte, never a quote, comma or newline
   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      if ($urandom_range(0, 7) == 0) return CH_RETURN;
      do b = 8'($urandom_range(0, 255));
      while (b == CH_QUOTE || b == CH_COMMA || b == CH_NEWLINE);
      return b;
   endfunction

   // one well-formed record, newline included, no longer than the limit
   function automatic void make_record(ref logic [7:0] rec[$], input int unsigned limit);
      int unsigned fields;
      int unsigned len;
      logic [7:0]  b;
      for (int tries = 0; tries < 8; tries++) begin
         rec.delete();
         fields = $urandom_range(1, 5);
         for (int f = 0; f < fields; f++) begin
            if (f > 0) rec.push_back(CH_COMMA);
            len = $urandom_range(0, 8);
            case ($urandom_range(0, 3))
               0: ;  // empty field
               1, 2: repeat (len) rec.push_back(plain_byte());
               default: begin
                  // quoted field: doubled quotes, commas and newlines as content
                  rec.push_back(CH_QUOTE);
                  repeat (len) begin
                     case ($urandom_range(0, 7))
                        0: begin
                           rec.push_back(CH_QUOTE);
                           rec.push_back(CH_QUOTE);
                        end
                        1: rec.push_back(CH_COMMA);
                        2: rec.push_back(CH_NEWLINE);
                        default: begin
                           do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE);
                           rec.push_back(b);
                        end
                     endcase
                  end
                  rec.push_back(CH_QUOTE);
               end
            endcase
         end
         rec.push_back(CH_NEWLINE);
         if (rec.size() <= limit) return;
      end
      // tight limits fall back to an empty record
      rec.delete();
      rec.push_back(CH_NEWLINE);
   endfunction

   // offer one word after a random gap and wait for the handshake
   task automatic send_word(input logic [7:0] value, input logic eoi);
      item_type word;
      int unsigned gap;
      word.byte_value   = value;
      word.end_of_input = eoi;
      gap = send_quiet ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= eoi;
      do @(posedge clock); while (!req_tready);
      sb.note_word(word);
   endtask

   // stop offering and wait until every predicted word has come back
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.expected_words.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // limit register is only touched while the block is idle
   task automatic write_limit(input logic [15:0] value);
      settle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.set_limit(value);
   endtask

   task automatic run_records(input int unsigned budget);
      logic [7:0]  rec[$];
      int unsigned start;
      start = sb.words_in;
      while (sb.words_in - start < budget) begin
         make_record(rec, sb.max_bytes);
         // some records go back to back with no sender gaps
         send_quiet = ($urandom_range(0, 5) == 0);
         foreach (rec[i]) send_word(rec[i], 1'b0);
      end
      send_quiet = 1'b0;
   endtask

   // one long record streamed at full rate on both sides
   task automatic send_long_record();
      send_quiet = 1'b1;
      recv_quiet = 1'b1;
      repeat (LONG_RECORD - 1) send_word(plain_byte(), 1'b0);
      send_word(CH_NEWLINE, 1'b0);
      send_quiet = 1'b0;
      recv_quiet = 1'b0;
   endtask

   // main stimulus
   initial begin
      closing_kind_type closing;
      logic [7:0]    rec[$];
      logic [7:0]    b;
      int unsigned   k;
      int unsigned   cut;
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: empty record, extreme bytes, empty fields, carriage return,
      // doubled quote and comma/newline inside quotes, closed quote then
      // quote, comma and newline
      rec = '{CH_NEWLINE,
              8'h00, 8'hFF, CH_COMMA, CH_COMMA, CH_RETURN, CH_NEWLINE,
              CH_QUOTE, CH_QUOTE, CH_QUOTE, CH_COMMA, CH_NEWLINE, CH_QUOTE,
              CH_COMMA, CH_QUOTE, CH_QUOTE, CH_NEWLINE};
      foreach (rec[i]) send_word(rec[i], 1'b0);

      // sink holds off for a long stretch early in this phase
      hold_rsp = 1'b1;
      run_records(320);

      // limit extremes and random settings in between
      write_limit(16'd1);
      run_records(40);
      write_limit(16'hFFFF);
      send_long_record();
      run_records(200);
      write_limit(16'($urandom_range(2, 40)));
      run_records(320);
      write_limit(16'($urandom_range(41, 65534)));
      run_records(320);
      write_limit(16'd2);
      run_records(60);

      // one closing case per run, picked by the seed
      write_limit(16'($urandom_range(64, 4096)));
      closing = closing_kind_type'($urandom_range(0, 5));
      case (closing)
         CLOSE_CLEAN: send_word(8'($urandom_range(0, 255)), 1'b1);
         CLOSE_TRUNCATED: begin
            // end mark inside a record, possibly inside quotes
            make_record(rec, sb.max_bytes);
            if (rec.size() == 1) rec[0] = plain_byte();
            cut = (rec.size() > 1) ? $urandom_range(1, rec.size() - 1) : 1;
            for (int i = 0; i < cut; i++) send_word(rec[i], 1'b0);
            send_word(8'($urandom_range(0, 255)), 1'b1);
         end
         CLOSE_TOO_LARGE: begin
            // limit lowered mid-record, next byte overflows
            k = $urandom_range(1, 12);
            repeat (k) send_word(plain_byte(), 1'b0);
            write_limit(16'($urandom_range(1, k)));
            repeat (3) send_word(plain_byte(), 1'b0);
         end
         CLOSE_BAD_QUOTE: begin
            repeat ($urandom_range(1, 5)) send_word(plain_byte(), 1'b0);
            send_word(CH_QUOTE, 1'b0);
         end
         CLOSE_STRAY_BYTE: begin
            send_word(CH_QUOTE, 1'b0);
            repeat ($urandom_range(0, 4)) send_word(plain_byte(), 1'b0);
            send_word(CH_QUOTE, 1'b0);
            send_word(plain_byte(), 1'b0);
         end
         default: begin
            // raw noise biased toward the special bytes
            repeat (60) begin
               case ($urandom_range(0, 5))
                  0: b = CH_QUOTE;
                  1: b = CH_COMMA;
                  2: b = CH_NEWLINE;
                  default: b = 8'($urandom_range(0, 255));
               endcase
               send_word(b, $urandom_range(0, 15) == 0);
            end
         end
      endcase

      // block should now answer every word from its locked state
      repeat (TAIL_WORDS) send_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);

      settle();
      repeat (8) @(posedge clock);

      $display("framer run: %0d words in, %0d results checked, %0d records framed",
               sb.words_in, sb.words_out, sb.records_framed);
      $display("limits 1, 2, 65535 and random, one %0d byte record, closing case %s",
               LONG_RECORD, closing.name());
      if (sb.failures == 0 && sb.expected_words.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // result sink with random stalls, quiet runs and one long hold-off
   initial begin
      int unsigned stall;
      int unsigned quiet_left;
      result_type  got;
      quiet_left = 0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            // long hold so the block fills and backs up the input
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            if (quiet_left == 0 && $urandom_range(0, 19) == 0) quiet_left = 30;
            if (quiet_left > 0) begin
               quiet_left--;
               stall = 0;
            end else begin
               stall = recv_quiet ? 0 : $urandom_range(0, GAP_MAX);
            end
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got = {rsp_tdata[55:24], rsp_tdata[23:8], rsp_tuser[3:2], rsp_tuser[1:0],
                rsp_tdata[7:0]};
         sb.check_word(got);
      end
   end

   // watchdog: too long without any handshake on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

endmodule
